/* src/efs_pkg.sv */
// ----------------------------------------------------------------------------
// efs_pkg
// Shared types, codes and the 3x3 kernel for the streaming edge filter.
// ----------------------------------------------------------------------------
`default_nettype none

package efs_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;

    // Input opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Result select bits: which windows an item emits, in output order
    localparam int unsigned SEL_FULL  = 0; // (older col, previous col, current col)
    localparam int unsigned SEL_EDGE1 = 1; // (previous col, current col, zero)
    localparam int unsigned SEL_EDGE2 = 2; // (current col, zero, zero)

    typedef logic [2:0] sel_mask_t;

    // One window column: gray values of the three rows
    typedef struct packed {
        logic [7:0] top;
        logic [7:0] mid;
        logic [7:0] bot;
    } column_t;

    // Hand-off from the line-buffer stage to the result stage
    typedef struct packed {
        column_t   win0;
        column_t   win1;
        column_t   cur;
        sel_mask_t mask;
        logic      image_end;
    } emit_load_t;

    // Kernel 1 2 1 / 2 -13 2 / 1 2 1 over columns p, q, r, clamped to 0..255
    function automatic logic [7:0] apply_kernel(column_t p, column_t q, column_t r);
        logic [11:0] pos;
        logic [11:0] neg;
        logic [11:0] diff;
        logic [7:0]  res;
        pos = 12'(p.top) + 12'(p.bot) + 12'(r.top) + 12'(r.bot)
            + ((12'(q.top) + 12'(q.bot) + 12'(p.mid) + 12'(r.mid)) << 1);
        neg  = (12'(q.mid) << 3) + (12'(q.mid) << 2) + 12'(q.mid);
        diff = pos - neg;
        if (pos < neg) begin
            res = 8'd0;
        end else if (diff > 12'd255) begin
            res = 8'd255;
        end else begin
            res = diff[7:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* src/edge_filter_3x3_stream.sv */
// ----------------------------------------------------------------------------
// edge_filter_3x3_stream
// Streaming 3x3 edge filter over raster-order pixels with clamped output.
// ----------------------------------------------------------------------------
// Accepts one item per cycle unless its results wait for the output stage.
// Each pixel reads its column from a single line buffer (older and newer row
// packed in one 16-bit word, registered read) and writes it back shifted by
// one row; a back-to-back transfer at the same column (width 1) is forwarded.
// Results leave through one kernel unit that evaluates one window per cycle
// unless the output is held, so an item's windows go out in turn: one for
// ordinary pixels, up to three at the last column of a row. The first two
// columns of the next row bring no result, so with the output ready the input
// does not stall. Inputs pass the line-buffer stage, the window registers and
// the output register. Drain items (2 * width of them) finish the last two
// output rows; drain items before the image ends and pixels during the drain
// are taken and ignored. Any write to a listed register restarts the image;
// widths are saturated to 1..MAX_WIDTH and heights to 2..MAX_HEIGHT.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_filter_3x3_stream #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data,
    // input stream
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_opcode,
    input  wire logic [7:0]  s_pixel_byte,
    // result stream
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_edge_value,
    output logic             m_last_of_run,
    output logic             m_last_of_image
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);
    localparam int RESET_W = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int RESET_H = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

    localparam efs_pkg::column_t ZERO_COL = '0;

    // configuration and position
    logic [WW-1:0] width_reg;
    logic [HW-1:0] height_reg;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;

    // line-buffer stage
    logic               b_valid_reg;
    logic [CW-1:0]      b_col_reg;
    logic [7:0]         b_gray_reg;
    efs_pkg::sel_mask_t b_mask_reg;
    logic               b_end_reg;
    logic               b_last_col_reg;
    logic               fwd_reg;
    logic [15:0]        fwd_data_reg;

    // window of the two previous columns
    efs_pkg::column_t win0_reg, win1_reg;

    logic               accept, pass, b_adv, cfg_hit;
    logic               last_col, final_row, row_ok;
    efs_pkg::sel_mask_t mask;
    logic [15:0]        ram_q, rd_word;
    efs_pkg::column_t   cur;
    efs_pkg::emit_load_t load_data;
    logic               e_ready, e_load;
    logic [WW-1:0]      width_next;
    logic [HW-1:0]      height_next;

    // register write, saturated
    always_comb begin
        if (cfg_data == 11'd0) begin
            width_next = WW'(1);
        end else if (32'(cfg_data) > MAX_WIDTH) begin
            width_next = WW'(MAX_WIDTH);
        end else begin
            width_next = WW'(cfg_data);
        end
        if (cfg_data < 11'd2) begin
            height_next = HW'(2);
        end else if (32'(cfg_data) > MAX_HEIGHT) begin
            height_next = HW'(MAX_HEIGHT);
        end else begin
            height_next = HW'(cfg_data);
        end
    end

    assign cfg_hit = cfg_wr_en && (cfg_index == efs_pkg::CFG_IMAGE_WIDTH
                                   || cfg_index == efs_pkg::CFG_IMAGE_HEIGHT);

    // input side
    assign b_adv   = b_valid_reg && ((b_mask_reg == '0) || e_ready);
    assign s_ready = !b_valid_reg || b_adv;
    assign accept  = s_valid && s_ready;
    assign row_ok  = (s_opcode == efs_pkg::OP_PIXEL) ? (row_reg < RW'(height_reg))
                                                     : (row_reg >= RW'(height_reg));
    assign pass    = accept && row_ok;

    assign last_col  = (WW'(col_reg) + WW'(1)) >= width_reg;
    assign final_row = row_reg >= (RW'(height_reg) + RW'(1));

    always_comb begin
        mask = '0;
        if (row_reg >= RW'(2)) begin
            mask[efs_pkg::SEL_FULL]  = (col_reg >= CW'(2));
            mask[efs_pkg::SEL_EDGE1] = last_col && (col_reg != '0);
            mask[efs_pkg::SEL_EDGE2] = last_col;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= WW'(RESET_W);
            height_reg  <= HW'(RESET_H);
            col_reg     <= '0;
            row_reg     <= '0;
            b_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
        end else begin
            if (cfg_hit) begin
                if (cfg_index == efs_pkg::CFG_IMAGE_WIDTH) begin
                    width_reg <= width_next;
                end else begin
                    height_reg <= height_next;
                end
                col_reg <= '0;
                row_reg <= '0;
            end else if (pass) begin
                if (last_col) begin
                    col_reg <= '0;
                    row_reg <= final_row ? '0 : row_reg + RW'(1);
                end else begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            if (pass) begin
                b_valid_reg <= 1'b1;
                // write-back of the leaving item lands on the same entry
                fwd_reg     <= b_adv && (b_col_reg == col_reg);
            end else if (b_adv) begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pass) begin
            b_col_reg      <= col_reg;
            b_gray_reg     <= (s_opcode == efs_pkg::OP_PIXEL) ? (s_pixel_byte ^ 8'h80)
                                                              : 8'd0;
            b_mask_reg     <= mask;
            b_end_reg      <= last_col && final_row;
            b_last_col_reg <= last_col;
            fwd_data_reg   <= {cur.mid, b_gray_reg};
        end
    end

    efs_line_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (16)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (b_adv),
        .wr_addr (b_col_reg),
        .wr_data ({cur.mid, b_gray_reg}),
        .rd_en   (pass),
        .rd_addr (col_reg),
        .rd_data (ram_q)
    );

    // older row in the high byte, newer row in the low byte
    assign rd_word = fwd_reg ? fwd_data_reg : ram_q;
    assign cur.top = rd_word[15:8];
    assign cur.mid = rd_word[7:0];
    assign cur.bot = b_gray_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win0_reg <= ZERO_COL;
            win1_reg <= ZERO_COL;
        end else if (cfg_hit) begin
            win0_reg <= ZERO_COL;
            win1_reg <= ZERO_COL;
        end else if (b_adv) begin
            if (b_last_col_reg) begin
                win0_reg <= ZERO_COL;
                win1_reg <= ZERO_COL;
            end else begin
                win0_reg <= win1_reg;
                win1_reg <= cur;
            end
        end
    end

    assign e_load              = b_adv && (b_mask_reg != '0);
    assign load_data.win0      = win0_reg;
    assign load_data.win1      = win1_reg;
    assign load_data.cur       = cur;
    assign load_data.mask      = b_mask_reg;
    assign load_data.image_end = b_end_reg;

    efs_emitter u_emitter (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (e_load),
        .load_data       (load_data),
        .load_ready      (e_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_edge_value    (m_edge_value),
        .m_last_of_run   (m_last_of_run),
        .m_last_of_image (m_last_of_image)
    );

endmodule

`default_nettype wire

/* src/efs_line_ram.sv */
// ----------------------------------------------------------------------------
// efs_line_ram
// Simple dual-port line buffer: one write, one read, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module efs_line_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* src/efs_emitter.sv */
// ----------------------------------------------------------------------------
// efs_emitter
// Result stage: steps through the up to three windows of one item, one
// kernel evaluation per cycle unless stalled, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module efs_emitter (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                load,
    input  wire efs_pkg::emit_load_t load_data,
    output logic                     load_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [7:0]               m_edge_value,
    output logic                     m_last_of_run,
    output logic                     m_last_of_image
);

    efs_pkg::column_t   win0_reg, win1_reg, cur_reg;
    efs_pkg::sel_mask_t mask_reg;
    logic               image_end_reg;
    logic               m_valid_reg;
    logic [7:0]         value_reg;
    logic               last_run_reg;
    logic               last_img_reg;

    efs_pkg::sel_mask_t sel;
    efs_pkg::sel_mask_t rem;
    efs_pkg::column_t   kp, kq, kr;
    logic               take;

    localparam efs_pkg::column_t ZERO_COL = '0;

    assign take = (mask_reg != '0) && (!m_valid_reg || m_ready);
    assign sel  = mask_reg & (~mask_reg + 3'd1);   // lowest pending window
    assign rem  = mask_reg & ~sel;
    assign load_ready = (mask_reg == '0) || (take && rem == '0);

    always_comb begin
        kp = cur_reg;
        kq = ZERO_COL;
        kr = ZERO_COL;
        priority if (sel[efs_pkg::SEL_FULL]) begin
            kp = win0_reg;
            kq = win1_reg;
            kr = cur_reg;
        end else if (sel[efs_pkg::SEL_EDGE1]) begin
            kp = win1_reg;
            kq = cur_reg;
        end else begin
            kp = cur_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                mask_reg <= load_data.mask;
            end else if (take) begin
                mask_reg <= rem;
            end
            if (take) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            win0_reg      <= load_data.win0;
            win1_reg      <= load_data.win1;
            cur_reg       <= load_data.cur;
            image_end_reg <= load_data.image_end;
        end
        if (take) begin
            value_reg    <= efs_pkg::apply_kernel(kp, kq, kr);
            last_run_reg <= (rem == '0);
            last_img_reg <= (rem == '0) && image_end_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_edge_value    = value_reg;
    assign m_last_of_run   = last_run_reg;
    assign m_last_of_image = last_img_reg;

endmodule

`default_nettype wire

/* tb/sv/edge_filter_3x3_stream_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_filter_3x3_stream_tb
// Self-checking bench for the streaming 3x3 edge filter.
// ----------------------------------------------------------------------------
// A short table of directed transfers runs first: reset geometry, saturated
// register values, early drains, pixels during the drain and a 3x2 image.
// Random images of mostly small shapes follow, with noise items, aborted
// images and two images cut short at saturated register values. Every
// accepted pixel or drain item goes through a cycle-free filter model in the
// bench, and every result transfer is compared with the oldest expected
// edge value and end flags.
// ----------------------------------------------------------------------------

module edge_filter_3x3_stream_tb;

    localparam int          CLK_PERIOD    = 12;
    localparam int          MAX_W         = 1024;
    localparam int          MAX_H         = 1024;
    localparam int          QUIET_CYCLES  = 8;
    localparam int          END_CYCLES    = 20;
    localparam int          RANDOM_ITEMS  = 430;
    localparam int          LONG_HOLD     = 300;
    localparam int          LONG_HOLD_AT  = 150;
    localparam int unsigned LIMIT_CYCLES  = 4000000;
    localparam int          PLAN_LEN      = 26;
    localparam logic [1:0]  CFG_UNLISTED  = 2'd3;

    typedef struct packed {
        logic [7:0] edge_value;
        logic       last_of_run;
        logic       last_of_image;
    } edge_res_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_PREDICT, ROW_QUIET, ROW_KNOWN} plan_kind_t;

    typedef struct packed {
        plan_kind_t  kind;
        logic [1:0]  reg_idx;
        logic [10:0] reg_val;
        logic        op;
        logic [7:0]  px;
        edge_res_t   known;
    } plan_row_t;

    localparam efs_pkg::column_t ZERO_COL = '0;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_opcode;
    logic [7:0]  s_pixel_byte;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_edge_value;
    logic        m_last_of_run;
    logic        m_last_of_image;

    edge_filter_3x3_stream DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_pixel_byte    (s_pixel_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_edge_value    (m_edge_value),
        .m_last_of_run   (m_last_of_run),
        .m_last_of_image (m_last_of_image)
    );

    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Filter model state
    // ------------------------------------------------------------------
    logic [7:0]       older_rows [MAX_W];
    logic [7:0]       newer_rows [MAX_W];
    efs_pkg::column_t prev2_col;
    efs_pkg::column_t prev1_col;
    int unsigned      row_pos;
    int unsigned      col_pos;
    logic [10:0]      width_reg;
    logic [10:0]      height_reg;
    edge_res_t        step_out [3];

    edge_res_t   expected_edges [$];
    edge_res_t   oldest_edge;
    plan_row_t   plan [PLAN_LEN];

    int          mismatch_count;
    int          results_seen;
    int          taken_total;
    int          ignored_items;
    int          random_taken;
    int          images_run;
    int          flush_pauses;
    int          long_holds;
    bit          burst_mode;
    bit          tally_on;
    int unsigned cycle_count;

    function automatic int unsigned active_width();
        if (width_reg == 11'd0) return 1;
        if (width_reg > MAX_W) return MAX_W;
        return 32'(width_reg);
    endfunction

    function automatic int unsigned active_height();
        if (height_reg < 11'd2) return 2;
        if (height_reg > MAX_H) return MAX_H;
        return 32'(height_reg);
    endfunction

    // Columns p, q, r; kernel 1 2 1 / 2 -13 2 / 1 2 1, clamped to a byte
    function automatic logic [7:0] filter_window(efs_pkg::column_t p,
                                                 efs_pkg::column_t q,
                                                 efs_pkg::column_t r);
        int acc;
        acc = int'(p.top) + int'(p.bot) + int'(r.top) + int'(r.bot)
            + 2 * (int'(q.top) + int'(q.bot) + int'(p.mid) + int'(r.mid))
            - 13 * int'(q.mid);
        if (acc < 0) return 8'd0;
        if (acc > 255) return 8'd255;
        return acc[7:0];
    endfunction

    // Returns the number of results left in step_out, or -1 when the item is dropped
    function automatic int predict_edges(logic op, logic [7:0] px);
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        efs_pkg::column_t cur;
        bit               at_last_col;
        bit               at_final_row;
        int               n;
        w = active_width();
        h = active_height();
        c = col_pos;
        n = 0;
        if (op == efs_pkg::OP_PIXEL) begin
            if (row_pos >= h) return -1;
            cur.bot = px + 8'd128;
        end else begin
            if (row_pos < h) return -1;
            cur.bot = 8'd0;
        end
        if (c >= w) c = w - 1;
        cur.top = older_rows[c];
        cur.mid = newer_rows[c];
        older_rows[c] = cur.mid;
        newer_rows[c] = cur.bot;
        at_last_col  = (c + 1 >= w);
        at_final_row = (row_pos + 1 >= h + 2);
        if (row_pos >= 2) begin
            if (c >= 2) begin
                step_out[n] = '0;
                step_out[n].edge_value = filter_window(prev2_col, prev1_col, cur);
                n++;
            end
            if (at_last_col) begin
                if (c >= 1) begin
                    step_out[n] = '0;
                    step_out[n].edge_value = filter_window(prev1_col, cur, ZERO_COL);
                    n++;
                end
                step_out[n] = '0;
                step_out[n].edge_value = filter_window(cur, ZERO_COL, ZERO_COL);
                n++;
            end
            if (n > 0) begin
                step_out[n - 1].last_of_run   = 1'b1;
                step_out[n - 1].last_of_image = at_last_col && at_final_row;
            end
        end
        prev2_col = prev1_col;
        prev1_col = cur;
        if (at_last_col) begin
            prev2_col = '0;
            prev1_col = '0;
            col_pos   = 0;
            row_pos   = at_final_row ? 0 : row_pos + 1;
        end else begin
            col_pos = c + 1;
        end
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Directed table rows
    // ------------------------------------------------------------------
    function automatic plan_row_t cfg_row(logic [1:0] idx, logic [10:0] val);
        plan_row_t r;
        r = '0;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic plan_row_t item_row(plan_kind_t kind, logic op, logic [7:0] px);
        plan_row_t r;
        r = '0;
        r.kind = kind;
        r.op   = op;
        r.px   = px;
        return r;
    endfunction

    function automatic plan_row_t known_row(logic op, logic [7:0] px, logic [7:0] val,
                                            logic run_end, logic img_end);
        plan_row_t r;
        r = item_row(ROW_KNOWN, op, px);
        r.known.edge_value    = val;
        r.known.last_of_run   = run_end;
        r.known.last_of_image = img_end;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    function automatic int sender_gap();
        int pick;
        if (burst_mode) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 65) return 0;
        if (pick < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_byte();
        logic [7:0] corners [4];
        corners = '{8'h00, 8'h7F, 8'h80, 8'hFF};
        if ($urandom_range(0, 99) < 15) return corners[$urandom_range(0, 3)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic transfer_item(input logic op, input logic [7:0] px, input int gap,
                                 output int n);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_pixel_byte <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n = predict_edges(op, px);
        taken_total++;
        if (n < 0) ignored_items++;
    endtask

    task automatic offer(input logic op, input logic [7:0] px);
        int n;
        transfer_item(op, px, sender_gap(), n);
        for (int k = 0; k < n; k++) expected_edges.push_back(step_out[k]);
        if (n >= 0 && tally_on) random_taken++;
    endtask

    // Stop offering until every predicted result has left the block
    task automatic let_block_settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_edges.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [10:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == efs_pkg::CFG_IMAGE_WIDTH) width_reg = val;
        if (idx == efs_pkg::CFG_IMAGE_HEIGHT) height_reg = val;
        if (idx == efs_pkg::CFG_IMAGE_WIDTH || idx == efs_pkg::CFG_IMAGE_HEIGHT) begin
            prev2_col = '0;
            prev1_col = '0;
            row_pos   = 0;
            col_pos   = 0;
        end
    endtask

    // One image: register writes, optional noise, pixels, then the drain rows.
    // A positive cut stops the image after that many pixels.
    task automatic run_image(input logic [10:0] wv, input logic [10:0] hv,
                             input bit both, input bit noisy, input int cut);
        int unsigned w;
        int unsigned npix;
        int unsigned p;
        int unsigned d;
        int          abort_at;
        int          pick;
        let_block_settle();
        pick = $urandom_range(0, 1);
        if (both || pick == 0) write_register(efs_pkg::CFG_IMAGE_WIDTH, wv);
        if (both || pick == 1) write_register(efs_pkg::CFG_IMAGE_HEIGHT, hv);
        images_run++;
        tally_on   = 1'b1;
        burst_mode = ($urandom_range(0, 3) == 0);
        w    = active_width();
        npix = w * active_height();
        abort_at = -1;
        if (cut > 0) abort_at = cut;
        if (noisy && flush_pauses > 0 && $urandom_range(0, 6) == 0)
            abort_at = $urandom_range(0, npix);
        if (noisy && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) offer(efs_pkg::OP_DRAIN, pick_byte());
        for (p = 0; p < npix && p != abort_at; p++) begin
            if (noisy && $urandom_range(0, 19) == 0) offer(efs_pkg::OP_DRAIN, pick_byte());
            if (noisy && ((flush_pauses == 0 && p == npix / 2) || $urandom_range(0, 199) == 0))
            begin
                let_block_settle();
                flush_pauses++;
            end
            offer(efs_pkg::OP_PIXEL, pick_byte());
        end
        if (abort_at < 0) begin
            if (noisy && $urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 3)) offer(efs_pkg::OP_PIXEL, pick_byte());
            for (d = 0; d < 2 * w; d++) begin
                if (noisy && $urandom_range(0, 24) == 0) offer(efs_pkg::OP_PIXEL, pick_byte());
                offer(efs_pkg::OP_DRAIN, pick_byte());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    initial begin : result_sink
        int hold_left;
        int calm_left;
        int pick;
        hold_left = 0;
        calm_left = 0;
        m_ready   = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (long_holds == 0 && taken_total >= LONG_HOLD_AT) begin
                // long back-pressure while the sender keeps offering
                long_holds++;
                hold_left = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else if (calm_left > 0) begin
                m_ready <= 1'b1;
                calm_left--;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    m_ready <= 1'b1;
                end else if (pick < 88) begin
                    m_ready <= 1'b0;
                    hold_left = $urandom_range(0, 2);
                end else if (pick < 96) begin
                    m_ready <= 1'b1;
                    calm_left = $urandom_range(20, 80);
                end else begin
                    m_ready <= 1'b0;
                    hold_left = $urandom_range(10, 40);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_edges.size() == 0) begin
                if (mismatch_count < 10)
                    $display("%0t: unexpected result edge=%0d run_end=%0b image_end=%0b",
                             $time, m_edge_value, m_last_of_run, m_last_of_image);
                mismatch_count++;
            end else begin
                oldest_edge = expected_edges.pop_front();
                if (m_edge_value !== oldest_edge.edge_value
                        || m_last_of_run !== oldest_edge.last_of_run
                        || m_last_of_image !== oldest_edge.last_of_image) begin
                    if (mismatch_count < 10) begin
                        $write("%0t: result %0d expected edge=%0d run_end=%0b image_end=%0b",
                               $time, results_seen, oldest_edge.edge_value,
                               oldest_edge.last_of_run, oldest_edge.last_of_image);
                        $display(", got edge=%0d run_end=%0b image_end=%0b",
                                 m_edge_value, m_last_of_run, m_last_of_image);
                    end
                    mismatch_count++;
                end
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_edges.size());
            $display("edge_filter_3x3_stream_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int n;
        int phase;
        int big_done;
        bit big_last;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = efs_pkg::CFG_IMAGE_WIDTH;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_opcode     = efs_pkg::OP_PIXEL;
        s_pixel_byte = '0;
        width_reg    = 11'd1024;
        height_reg   = 11'd1024;
        prev2_col    = '0;
        prev1_col    = '0;
        row_pos      = 0;
        col_pos      = 0;
        foreach (older_rows[i]) begin
            older_rows[i] = '0;
            newer_rows[i] = '0;
        end
        mismatch_count = 0;
        results_seen   = 0;
        taken_total    = 0;
        ignored_items  = 0;
        random_taken   = 0;
        images_run     = 0;
        flush_pauses   = 0;
        long_holds     = 0;
        burst_mode     = 1'b0;
        tally_on       = 1'b0;
        cycle_count    = 0;

        plan = '{
            item_row(ROW_QUIET, efs_pkg::OP_DRAIN, 8'hA5),  // early drain right after reset
            item_row(ROW_QUIET, efs_pkg::OP_PIXEL, 8'h00),  // top row: no window yet
            cfg_row(CFG_UNLISTED, 11'h7FF),                 // no such register: no restart
            item_row(ROW_QUIET, efs_pkg::OP_PIXEL, 8'hFF),
            cfg_row(efs_pkg::CFG_IMAGE_WIDTH, 11'd0),       // reads as width 1
            cfg_row(efs_pkg::CFG_IMAGE_HEIGHT, 11'd1),      // reads as height 2
            item_row(ROW_QUIET, efs_pkg::OP_PIXEL, 8'h7F),  // gray 255
            item_row(ROW_QUIET, efs_pkg::OP_PIXEL, 8'h80),  // gray 0
            item_row(ROW_QUIET, efs_pkg::OP_PIXEL, 8'h3C),  // pixel during drain: dropped
            known_row(efs_pkg::OP_DRAIN, 8'h00, 8'd255, 1'b1, 1'b0),
            known_row(efs_pkg::OP_DRAIN, 8'hFF, 8'd0, 1'b1, 1'b1),
            item_row(ROW_QUIET, efs_pkg::OP_DRAIN, 8'h5A),  // next image not started
            cfg_row(efs_pkg::CFG_IMAGE_WIDTH, 11'd3),
            cfg_row(efs_pkg::CFG_IMAGE_HEIGHT, 11'd2),
            item_row(ROW_PREDICT, efs_pkg::OP_PIXEL, 8'h7F),
            item_row(ROW_PREDICT, efs_pkg::OP_PIXEL, 8'h80),
            item_row(ROW_PREDICT, efs_pkg::OP_PIXEL, 8'hFF),
            item_row(ROW_PREDICT, efs_pkg::OP_PIXEL, 8'h00),
            item_row(ROW_PREDICT, efs_pkg::OP_PIXEL, 8'h7F),
            item_row(ROW_PREDICT, efs_pkg::OP_PIXEL, 8'h01),
            item_row(ROW_PREDICT, efs_pkg::OP_DRAIN, 8'h00),
            item_row(ROW_PREDICT, efs_pkg::OP_DRAIN, 8'hFF),
            item_row(ROW_PREDICT, efs_pkg::OP_DRAIN, 8'h80),
            item_row(ROW_PREDICT, efs_pkg::OP_DRAIN, 8'h7F),
            item_row(ROW_PREDICT, efs_pkg::OP_DRAIN, 8'h00),
            item_row(ROW_PREDICT, efs_pkg::OP_DRAIN, 8'h55)
        };

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_CFG: begin
                    let_block_settle();
                    write_register(plan[i].reg_idx, plan[i].reg_val);
                end
                ROW_PREDICT: begin
                    offer(plan[i].op, plan[i].px);
                end
                default: begin
                    transfer_item(plan[i].op, plan[i].px, sender_gap(), n);
                    if (plan[i].kind == ROW_KNOWN) expected_edges.push_back(plan[i].known);
                end
            endcase
        end

        // Random images: mostly small, two cut short at saturated register values
        phase    = 0;
        big_done = 0;
        big_last = 1'b1;
        while (random_taken < RANDOM_ITEMS || big_done < 2) begin
            if (big_done < 2 && (phase % 6 == 3 || random_taken >= RANDOM_ITEMS)) begin
                if (big_done == 0) run_image(11'd2047, 11'd0, 1'b1, 1'b0, 24);
                else run_image(11'd1, 11'd2047, 1'b1, 1'b0, 80);
                big_done++;
                big_last = 1'b1;
            end else begin
                run_image($urandom_range(0, 9) < 6 ? 11'($urandom_range(1, 8))
                              : ($urandom_range(0, 3) != 0 ? 11'($urandom_range(9, 24))
                                                           : 11'($urandom_range(0, 3))),
                          $urandom_range(0, 9) < 7 ? 11'($urandom_range(2, 5))
                              : ($urandom_range(0, 2) != 0 ? 11'($urandom_range(6, 10))
                                                           : 11'($urandom_range(0, 1))),
                          big_last || $urandom_range(0, 3) != 0, 1'b1, 0);
                big_last = 1'b0;
            end
            phase++;
        end

        burst_mode = 1'b0;
        let_block_settle();
        repeat (END_CYCLES) @(posedge aclk);

        $display("summary: %0d transfers in (%0d dropped by the filter), %0d results, %0d images",
                 taken_total, ignored_items, results_seen, images_run);
        $display("summary: widths 1..24 plus saturated registers, %0d long output stalls, %0d flushes",
                 long_holds, flush_pauses);
        if (mismatch_count == 0 && expected_edges.size() == 0) begin
            $display("edge_filter_3x3_stream_tb: clean");
        end else begin
            $display("edge_filter_3x3_stream_tb: errors");
        end
        $finish;
    end

endmodule
